[rtl/guide_vane_closing_fault_monitor_macros.svh]
// Assertion helpers shared by the monitor RTL
`ifndef GUIDE_VANE_CLOSING_FAULT_MONITOR_MACROS_SVH
`define GUIDE_VANE_CLOSING_FAULT_MONITOR_MACROS_SVH

// same-cycle implication
`define GVCFM_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("gvcfm assertion failed");

// next-cycle implication
`define GVCFM_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("gvcfm assertion failed");

`endif

[rtl/gvcfm_pkg.sv]
package gvcfm_pkg;

  localparam int WINDOW_DEF = 100;
  localparam int POS_W      = 16;
  localparam int THR_W      = 24;
  localparam int MIN_W      = 7;
  localparam int CFG_IDX_W  = 2;

  localparam logic [POS_W-1:0] Q15_ONE = 16'd32768;

  localparam logic [THR_W-1:0] RATE_THR_RST = 24'd42598;
  localparam logic [THR_W-1:0] JUMP_THR_RST = 24'd6554;
  localparam logic [MIN_W-1:0] MIN_CLOSE_RST = 7'd10;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_RATE_THR  = 2'd0,
    CFG_JUMP_THR  = 2'd1,
    CFG_MIN_CLOSE = 2'd2
  } cfg_idx_t;

  typedef struct packed {
    logic [POS_W-1:0] position_sample;
    logic [POS_W-1:0] servo_output;
    logic [POS_W-1:0] regulator_feedback;
  } in_t;

  typedef struct packed {
    logic zero_drift_fault;
    logic fast_close_fault;
    logic jump_fault;
  } out_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SCAN,
    ST_LAST,
    ST_MUL,
    ST_DIV,
    ST_FIN
  } state_t;

endpackage

[rtl/gvcfm_hist.sv]
module gvcfm_hist #(
  parameter int WINDOW = gvcfm_pkg::WINDOW_DEF
) (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               rd_en,
  input  logic [$clog2(WINDOW)-1:0]          rd_addr,
  output logic [gvcfm_pkg::POS_W-1:0]        rd_data,
  input  logic                               wr_en,
  input  logic [$clog2(WINDOW)-1:0]          wr_addr,
  input  logic [gvcfm_pkg::POS_W-1:0]        wr_data
);
  import gvcfm_pkg::*;

  localparam int CNT_W = $clog2(WINDOW + 1);

  logic [POS_W-1:0] mem [WINDOW];
  logic [POS_W-1:0] rd_q;
  logic             rd_ok;
  logic [CNT_W-1:0] fill;

  // slots are written in order from 0, so slot s holds data once fill > s
  always_ff @(posedge clk) begin
    if (rst) begin
      fill <= '0;
    end else if (wr_en && fill != CNT_W'(WINDOW)) begin
      fill <= fill + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_q  <= mem[rd_addr];
      rd_ok <= CNT_W'(rd_addr) < fill;
    end
  end

  assign rd_data = rd_ok ? rd_q : Q15_ONE;

endmodule

[rtl/gvcfm_div.sv]
module gvcfm_div #(
  parameter int NUM_W = 23,
  parameter int DEN_W = 7
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             start,
  input  logic [NUM_W-1:0] dividend,
  input  logic [DEN_W-1:0] divisor,
  output logic             done,
  output logic [NUM_W-1:0] quotient
);

  localparam int CW = $clog2(NUM_W);

  logic             busy;
  logic [CW-1:0]    cnt;
  logic [NUM_W-1:0] acc;
  logic [DEN_W-1:0] rem;
  logic [DEN_W-1:0] den;
  logic [DEN_W:0]   rem_sh;
  logic [DEN_W:0]   rem_sub;
  logic             ge;

  // restoring division, one quotient bit per cycle
  always_comb begin
    rem_sh  = {rem, acc[NUM_W-1]};
    ge      = rem_sh >= {1'b0, den};
    rem_sub = rem_sh - {1'b0, den};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= '0;
      end else if (busy) begin
        cnt <= cnt + 1'b1;
        if (cnt == CW'(NUM_W - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      acc <= dividend;
      rem <= '0;
      den <= divisor;
    end else if (busy) begin
      acc <= {acc[NUM_W-2:0], ge};
      rem <= ge ? rem_sub[DEN_W-1:0] : rem_sh[DEN_W-1:0];
    end
  end

  assign quotient = acc;

endmodule

[rtl/guide_vane_closing_fault_monitor.sv]
// channel  dir  handshake            payload
// in       in   in_valid/in_ready    in_data  (position, servo, feedback)
// out      out  out_valid/out_ready  out_data (three fault flags)
// cfg      in   cfg_we               cfg_index, cfg_data
//
// The duration of a transaction is set by the history scan (one memory read per
// cycle) and the bit-serial divider.
// in_ready is high only while idle; a result held in the output register keeps
// the finished transaction in ST_FIN, so it blocks the next transaction too.
// Synchronous reset; history reads as fully open until written.
`include "guide_vane_closing_fault_monitor_macros.svh"

module guide_vane_closing_fault_monitor #(
  parameter int WINDOW = gvcfm_pkg::WINDOW_DEF
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                in_valid,
  output logic                                in_ready,
  input  gvcfm_pkg::in_t                      in_data,
  output logic                                out_valid,
  input  logic                                out_ready,
  output gvcfm_pkg::out_t                     out_data,
  input  logic                                cfg_we,
  input  logic [gvcfm_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [gvcfm_pkg::THR_W-1:0]         cfg_data
);
  import gvcfm_pkg::*;

  localparam int IDX_W = $clog2(WINDOW);
  localparam int CNT_W = $clog2(WINDOW + 1);
  localparam int NUM_W = POS_W + CNT_W;
  localparam int CMP_W = (NUM_W > THR_W) ? NUM_W : THR_W;
  localparam int EL_W  = (CNT_W > MIN_W) ? CNT_W : MIN_W;
  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(WINDOW - 1);

  state_t state, state_next;

  logic [THR_W-1:0] rate_thr;
  logic [THR_W-1:0] jump_thr;
  logic [MIN_W-1:0] min_close;

  logic [POS_W-1:0] x_pos;
  logic             drift;
  logic [IDX_W-1:0] oldest;
  logic [IDX_W-1:0] issue_cnt;
  logic [IDX_W-1:0] rd_ptr;
  logic             chk;
  logic [IDX_W-1:0] chk_age;
  logic             found;
  logic [POS_W-1:0] start_pos;
  logic [POS_W-1:0] newest;
  logic [IDX_W-1:0] k;
  logic [NUM_W-1:0] local_rate;
  logic [CNT_W-1:0] elapsed;

  logic             rd_en;
  logic             mem_we;
  logic             div_start;
  logic             out_load;
  logic [POS_W-1:0] rd_data;
  logic             div_done;
  logic [NUM_W-1:0] quot;

  logic [POS_W-1:0] d_start;
  logic [POS_W-1:0] d_newest;
  logic [NUM_W-1:0] num;
  logic [CNT_W-1:0] den;
  logic [CMP_W-1:0] g_ext;
  logic [CMP_W-1:0] l_ext;
  logic [CMP_W-1:0] gl_diff;
  out_t             flags;

  always_ff @(posedge clk) begin
    if (rst) begin
      rate_thr  <= RATE_THR_RST;
      jump_thr  <= JUMP_THR_RST;
      min_close <= MIN_CLOSE_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_RATE_THR:  rate_thr  <= cfg_data;
        CFG_JUMP_THR:  jump_thr  <= cfg_data;
        CFG_MIN_CLOSE: min_close <= cfg_data[MIN_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: if (in_valid) state_next = ST_SCAN;
      ST_SCAN: if (issue_cnt == LAST_IDX) state_next = ST_LAST;
      ST_LAST: state_next = ST_MUL;
      ST_MUL:  state_next = ST_DIV;
      ST_DIV:  if (div_done) state_next = ST_FIN;
      ST_FIN:  if (!out_valid || out_ready) state_next = ST_IDLE;
      default: state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    in_ready  = 1'b0;
    rd_en     = 1'b0;
    mem_we    = 1'b0;
    div_start = 1'b0;
    out_load  = 1'b0;
    case (state)
      ST_IDLE: in_ready = 1'b1;
      ST_SCAN: rd_en = 1'b1;
      ST_MUL: begin
        mem_we    = 1'b1;
        div_start = 1'b1;
      end
      ST_FIN:  out_load = !out_valid || out_ready;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      oldest    <= '0;
      issue_cnt <= '0;
      rd_ptr    <= '0;
      chk       <= 1'b0;
      found     <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      chk <= rd_en;
      if (in_valid && in_ready) begin
        issue_cnt <= '0;
        rd_ptr    <= oldest;
        found     <= 1'b0;
      end
      if (rd_en) begin
        issue_cnt <= issue_cnt + 1'b1;
        rd_ptr    <= (rd_ptr == LAST_IDX) ? '0 : rd_ptr + 1'b1;
      end
      if (chk && !found && (rd_data != Q15_ONE || chk_age == LAST_IDX)) begin
        found <= 1'b1;
      end
      if (mem_we) begin
        oldest <= (oldest == LAST_IDX) ? '0 : oldest + 1'b1;
      end
      if (out_load) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      x_pos <= in_data.position_sample;
      drift <= (in_data.servo_output == '0) && (in_data.regulator_feedback != Q15_ONE);
    end
    chk_age <= issue_cnt;
    if (chk && !found && (rd_data != Q15_ONE || chk_age == LAST_IDX)) begin
      start_pos <= rd_data;
      k         <= chk_age;
    end
    if (chk && chk_age == LAST_IDX) begin
      newest <= rd_data;
    end
    if (mem_we) begin
      local_rate <= NUM_W'(d_newest) * NUM_W'(WINDOW);
      elapsed    <= den;
    end
    if (out_load) begin
      out_data <= flags;
    end
  end

  always_comb begin
    d_start  = (start_pos > x_pos) ? start_pos - x_pos : x_pos - start_pos;
    d_newest = (newest > x_pos) ? newest - x_pos : x_pos - newest;
    num      = NUM_W'(d_start) * NUM_W'(WINDOW);
    den      = CNT_W'(WINDOW) - CNT_W'(k);
  end

  always_comb begin
    g_ext   = CMP_W'(quot);
    l_ext   = CMP_W'(local_rate);
    gl_diff = (g_ext > l_ext) ? g_ext - l_ext : l_ext - g_ext;
    flags.zero_drift_fault = drift;
    flags.fast_close_fault = (g_ext > CMP_W'(rate_thr)) && (l_ext > CMP_W'(rate_thr)) &&
                             (EL_W'(elapsed) > EL_W'(min_close));
    flags.jump_fault       = gl_diff > CMP_W'(jump_thr);
  end

  gvcfm_hist #(
    .WINDOW (WINDOW)
  ) u_hist (
    .clk     (clk),
    .rst     (rst),
    .rd_en   (rd_en),
    .rd_addr (rd_ptr),
    .rd_data (rd_data),
    .wr_en   (mem_we),
    .wr_addr (oldest),
    .wr_data (x_pos)
  );

  gvcfm_div #(
    .NUM_W (NUM_W),
    .DEN_W (CNT_W)
  ) u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (num),
    .divisor  (den),
    .done     (div_done),
    .quotient (quot)
  );

  `GVCFM_ASSERT_NOW(a_done_in_div, div_done, state == ST_DIV)
  `GVCFM_ASSERT_NOW(a_found_by_mul, state == ST_MUL, found)
  `GVCFM_ASSERT_NEXT(a_accept_scans, in_valid && in_ready, state == ST_SCAN && !found)
  `GVCFM_ASSERT_NOW(a_out_from_fin, $rose(out_valid), $past(state) == ST_FIN)

endmodule
